@@ hdl/bfa_pkg.sv @@
// Shared widths, request and status codes, and register indexes of the frame allocator.
package bfa_pkg;

   // Fixed field widths
   localparam int ADDR_W    = 48;
   localparam int FRAME_W   = 36;
   localparam int ACTION_W  = 2;
   localparam int STATUS_W  = 3;
   localparam int CSR_IDX_W = 3;
   localparam int COUNT_W   = 2;
   localparam int NUM_SLOTS = 3;
   localparam int RSEL_W    = 2;

   typedef logic [FRAME_W-1:0]  frame_num_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [ACTION_W-1:0] action_type;

   // Request actions
   localparam action_type ACT_RESERVE  = 2'd0;
   localparam action_type ACT_ALLOCATE = 2'd1;
   localparam action_type ACT_FREE     = 2'd2;

   // Result status codes
   localparam status_type ST_OK       = 3'd0;
   localparam status_type ST_TAKEN    = 3'd1;
   localparam status_type ST_FREE     = 3'd2;
   localparam status_type ST_NO_FRAME = 3'd3;
   localparam status_type ST_NONE     = 3'd4;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_R0_FIRST     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_R0_LAST      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_R1_FIRST     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_R1_LAST      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_R2_FIRST     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_R2_LAST      = 3'd6;

endpackage

@@ hdl/bfa_bitmap.sv @@
// Occupancy bitmap memory with per-word full flags and a clearing pass after reset.
module bfa_bitmap #(
   parameter int DEPTH = 192,
   parameter int WIDTH = 64
) (
   input  logic                                   clock,
   input  logic                                   reset,
   output logic                                   ready,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   output logic [DEPTH-1:0]                       full
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;
   logic [DEPTH-1:0] full_ff;
   logic             clr_busy_ff;
   logic [AW-1:0]    clr_addr_ff;
   logic             mem_we;
   logic [AW-1:0]    mem_waddr;
   logic [WIDTH-1:0] mem_wdata;

   // clearing pass owns the write port until every word is zero
   assign mem_we    = clr_busy_ff | wr_en;
   assign mem_waddr = clr_busy_ff ? clr_addr_ff : wr_addr;
   assign mem_wdata = clr_busy_ff ? '0 : wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         if (clr_addr_ff == AW'(DEPTH - 1)) begin
            clr_busy_ff <= 1'b0;
         end
         clr_addr_ff <= clr_addr_ff + 1'b1;
      end
   end

   // word storage, one read and one write port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   // full flags track every write-back
   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= '0;
      end else if (wr_en) begin
         full_ff[wr_addr] <= &wr_data;
      end
   end

   assign ready   = ~clr_busy_ff;
   assign rd_data = rd_data_ff;
   assign full    = full_ff;

endmodule

@@ hdl/bitmap_frame_allocator_core.sv @@
// Top level of the bitmap page-frame allocator: config registers, sequencer, bitmap access.
//
// Usage: an item (req_action, req_phys_address) is taken at a clock edge where start is
// high and busy is low. Each item gives exactly one result on rsp_status and
// rsp_frame_address, shown for one cycle with rsp_valid high; the receiver cannot stall.
// Registers are to be written by the user through csr_we / csr_index / csr_wdata only while
// the block is idle; the block itself does not enforce this. Steps per item:
//   reserve, free   : region lookup, frame-to-word divide, bitmap read-modify-write
//   allocate        : word search, redone for each region whose partial last word turns out
//                     to hold no free frame (at most NUM_REGIONS retries)
//   unknown action  : answered in the cycle after it is taken
// The bitmap memory has one read and one write port; each item writes back at most one word.
// A new item is accepted in the same cycle its predecessor's result shows.
// After reset the bitmap memory, NUM_REGIONS times ceil(FRAMES_PER_REGION / WORD_BITS) words
// (192 by default), is cleared one word per cycle, with busy held high;
// register writes are taken during that time.
module bitmap_frame_allocator_core #(
   parameter int NUM_REGIONS       = 3,
   parameter int FRAMES_PER_REGION = 4096,
   parameter int WORD_BITS         = 64,
   parameter int PAGE_SHIFT        = 12
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [bfa_pkg::ACTION_W-1:0]    req_action,
   input  logic [bfa_pkg::ADDR_W-1:0]      req_phys_address,
   output logic                            rsp_valid,
   output logic [bfa_pkg::STATUS_W-1:0]    rsp_status,
   output logic [bfa_pkg::ADDR_W-1:0]      rsp_frame_address,
   input  logic                            csr_we,
   input  logic [bfa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bfa_pkg::FRAME_W-1:0]     csr_wdata
);

   localparam int WPR     = (FRAMES_PER_REGION + WORD_BITS - 1) / WORD_BITS;
   localparam int TOTAL   = NUM_REGIONS * WPR;
   localparam int AW      = (TOTAL > 1) ? $clog2(TOTAL) : 1;
   localparam int KW      = (WPR > 1) ? $clog2(WPR) : 1;
   localparam int BW      = $clog2(WORD_BITS);
   localparam int LIM_W   = BW + 1;
   localparam int IDX_W   = $clog2(FRAMES_PER_REGION);
   localparam int SZ_W    = $clog2(FRAMES_PER_REGION + 1);
   localparam int FN_W    = bfa_pkg::ADDR_W - PAGE_SHIFT;
   localparam int CW      = ((FN_W > bfa_pkg::FRAME_W) ? FN_W : bfa_pkg::FRAME_W) + 1;
   localparam int BASE_W  = bfa_pkg::FRAME_W + 1;
   localparam int RSH     = IDX_W + 7;
   localparam int RW      = RSH + 1;
   localparam longint unsigned RECIP = ((64'd1 << RSH) + WORD_BITS - 1) / WORD_BITS;
   localparam int PROD_W  = IDX_W + RW;

   typedef enum logic [2:0] {S_IDLE, S_LOOK, S_DIV, S_ELIG, S_PICK, S_MOD} state_type;

   // ---------------- configuration registers ----------------
   logic [bfa_pkg::COUNT_W-1:0] count_ff;
   bfa_pkg::frame_num_type      first_ff [bfa_pkg::NUM_SLOTS];
   bfa_pkg::frame_num_type      last_ff  [bfa_pkg::NUM_SLOTS];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= bfa_pkg::COUNT_W'(1);
         first_ff[0] <= '0;
         first_ff[1] <= '0;
         first_ff[2] <= '0;
         last_ff[0]  <= bfa_pkg::FRAME_W'(4095);
         last_ff[1]  <= '0;
         last_ff[2]  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            bfa_pkg::CSR_REGION_COUNT: count_ff    <= csr_wdata[bfa_pkg::COUNT_W-1:0];
            bfa_pkg::CSR_R0_FIRST:     first_ff[0] <= csr_wdata;
            bfa_pkg::CSR_R0_LAST:      last_ff[0]  <= csr_wdata;
            bfa_pkg::CSR_R1_FIRST:     first_ff[1] <= csr_wdata;
            bfa_pkg::CSR_R1_LAST:      last_ff[1]  <= csr_wdata;
            bfa_pkg::CSR_R2_FIRST:     first_ff[2] <= csr_wdata;
            bfa_pkg::CSR_R2_LAST:      last_ff[2]  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // region sizes, clamped to the bitmap span
   logic [SZ_W-1:0]             size_w [bfa_pkg::NUM_SLOTS];
   logic [BASE_W-1:0]           span   [bfa_pkg::NUM_SLOTS];
   logic [bfa_pkg::COUNT_W-1:0] act_n;

   always_comb begin
      for (int r = 0; r < bfa_pkg::NUM_SLOTS; r++) begin
         span[r] = {1'b0, last_ff[r]} - {1'b0, first_ff[r]} + 1'b1;
         if (last_ff[r] < first_ff[r]) begin
            size_w[r] = '0;
         end else if (span[r] > BASE_W'(FRAMES_PER_REGION)) begin
            size_w[r] = SZ_W'(FRAMES_PER_REGION);
         end else begin
            size_w[r] = span[r][SZ_W-1:0];
         end
      end
      act_n = (count_ff > bfa_pkg::COUNT_W'(NUM_REGIONS)) ?
              bfa_pkg::COUNT_W'(NUM_REGIONS) : count_ff;
   end

   // ---------------- sequencer registers ----------------
   state_type                    state_ff, state_in;
   bfa_pkg::action_type          op_ff, op_in;
   logic [FN_W-1:0]              fn_ff, fn_in;
   logic [bfa_pkg::RSEL_W-1:0]   sel_ff, sel_in;
   logic [IDX_W-1:0]             idx_ff, idx_in;
   logic [KW-1:0]                q_ff, q_in;
   logic [AW-1:0]                word_ff, word_in;
   logic [BASE_W-1:0]            base_ff, base_in;
   logic [LIM_W-1:0]             lim_ff, lim_in;
   logic [bfa_pkg::NUM_SLOTS-1:0] skip_ff, skip_in;
   logic [TOTAL-1:0]             elig_ff, elig_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   bfa_pkg::status_type          rsp_status_ff, rsp_status_in;
   logic [bfa_pkg::ADDR_W-1:0]   rsp_addr_ff, rsp_addr_in;

   // bitmap port
   logic                 mem_ready;
   logic [AW-1:0]        rd_addr;
   logic [WORD_BITS-1:0] rd_data;
   logic                 wr_en;
   logic [WORD_BITS-1:0] wr_data;
   logic [TOTAL-1:0]     full;

   bfa_bitmap #(
      .DEPTH (TOTAL),
      .WIDTH (WORD_BITS)
   ) u_bitmap (
      .clock   (clock),
      .reset   (reset),
      .ready   (mem_ready),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (word_ff),
      .wr_data (wr_data),
      .full    (full)
   );

   // ---------------- region lookup for reserve / free ----------------
   logic [CW-1:0]              lk_fn;
   logic [CW-1:0]              lk_off [bfa_pkg::NUM_SLOTS];
   logic                       lk_hit;
   logic [bfa_pkg::RSEL_W-1:0] lk_sel;
   logic [IDX_W-1:0]           lk_idx;

   always_comb begin
      lk_fn  = CW'(fn_ff);
      lk_hit = 1'b0;
      lk_sel = '0;
      lk_idx = '0;
      for (int r = 0; r < bfa_pkg::NUM_SLOTS; r++) begin
         lk_off[r] = lk_fn - CW'(first_ff[r]);
      end
      // lowest region index that holds the frame wins
      for (int r = NUM_REGIONS - 1; r >= 0; r--) begin
         if ((bfa_pkg::COUNT_W'(r) < act_n) && (lk_fn >= CW'(first_ff[r])) &&
             (lk_off[r] < CW'(size_w[r]))) begin
            lk_hit = 1'b1;
            lk_sel = bfa_pkg::RSEL_W'(r);
            lk_idx = lk_off[r][IDX_W-1:0];
         end
      end
   end

   // offset to word by reciprocal multiply; remainder taken after the read
   logic [PROD_W-1:0] dv_prod;
   logic [KW-1:0]     dv_q;
   logic [AW-1:0]     dv_word;
   logic [IDX_W-1:0]  md_rem;
   logic [BW-1:0]     md_bit;

   assign dv_prod = PROD_W'(idx_ff) * PROD_W'(RECIP);
   assign dv_q    = dv_prod[RSH +: KW];
   assign dv_word = AW'(int'(sel_ff) * WPR) + AW'(dv_q);
   assign md_rem  = idx_ff - IDX_W'(int'(q_ff) * WORD_BITS);
   assign md_bit  = md_rem[BW-1:0];

   // ---------------- candidate words for allocate ----------------
   logic [TOTAL-1:0] el_vec;

   always_comb begin
      logic in_rg;
      logic part;
      in_rg = 1'b0;
      part  = 1'b0;
      for (int r = 0; r < NUM_REGIONS; r++) begin
         for (int k = 0; k < WPR; k++) begin
            in_rg = (bfa_pkg::COUNT_W'(r) < act_n) &&
                    ((SZ_W + 1)'(k * WORD_BITS) < {1'b0, size_w[r]});
            part  = (SZ_W + 1)'((k + 1) * WORD_BITS) > {1'b0, size_w[r]};
            el_vec[r*WPR + k] = in_rg && !full[r*WPR + k] && !(part && skip_ff[r]);
         end
      end
   end

   // first candidate word: region order, then lowest word
   logic [NUM_REGIONS-1:0]     pr_found;
   logic [KW-1:0]              pr_k [NUM_REGIONS];
   logic                       pk_found;
   logic [bfa_pkg::RSEL_W-1:0] pk_sel;
   logic [KW-1:0]              pk_k;
   logic [AW-1:0]              pk_word;
   logic [SZ_W:0]              pk_rem;

   always_comb begin
      for (int r = 0; r < NUM_REGIONS; r++) begin
         pr_found[r] = 1'b0;
         pr_k[r]     = '0;
         for (int k = WPR - 1; k >= 0; k--) begin
            if (elig_ff[r*WPR + k]) begin
               pr_found[r] = 1'b1;
               pr_k[r]     = KW'(k);
            end
         end
      end
      pk_found = 1'b0;
      pk_sel   = '0;
      pk_k     = '0;
      for (int r = NUM_REGIONS - 1; r >= 0; r--) begin
         if (pr_found[r]) begin
            pk_found = 1'b1;
            pk_sel   = bfa_pkg::RSEL_W'(r);
            pk_k     = pr_k[r];
         end
      end
      pk_word = AW'(int'(pk_sel) * WPR) + AW'(pk_k);
      pk_rem  = (SZ_W + 1)'(size_w[pk_sel]) - (SZ_W + 1)'(int'(pk_k) * WORD_BITS);
   end

   assign rd_addr = (state_ff == S_PICK) ? pk_word : dv_word;

   // ---------------- word modify ----------------
   logic [WORD_BITS-1:0] al_avail;
   logic [BW-1:0]        al_bit;
   logic [BASE_W-1:0]    al_frame;

   always_comb begin
      al_bit = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         al_avail[i] = !rd_data[i] && (LIM_W'(i) < lim_ff);
      end
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (al_avail[i]) begin
            al_bit = BW'(i);
         end
      end
      al_frame = base_ff + BASE_W'(al_bit);
   end

   // ---------------- sequencer next state ----------------
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      fn_in         = fn_ff;
      sel_in        = sel_ff;
      idx_in        = idx_ff;
      q_in          = q_ff;
      word_in       = word_ff;
      base_in       = base_ff;
      lim_in        = lim_ff;
      skip_in       = skip_ff;
      elig_in       = elig_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      wr_en         = 1'b0;
      wr_data       = rd_data;

      unique case (state_ff)
         S_IDLE: begin
            if (start && mem_ready) begin
               op_in   = req_action;
               fn_in   = req_phys_address[bfa_pkg::ADDR_W-1:PAGE_SHIFT];
               skip_in = '0;
               if (req_action == bfa_pkg::ACT_RESERVE || req_action == bfa_pkg::ACT_FREE) begin
                  state_in = S_LOOK;
               end else if (req_action == bfa_pkg::ACT_ALLOCATE) begin
                  state_in = S_ELIG;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = bfa_pkg::ST_NO_FRAME;
                  rsp_addr_in   = '0;
               end
            end
         end
         S_LOOK: begin
            sel_in = lk_sel;
            idx_in = lk_idx;
            if (lk_hit) begin
               state_in = S_DIV;
            end else begin
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = bfa_pkg::ST_NO_FRAME;
               rsp_addr_in   = '0;
            end
         end
         S_DIV: begin
            q_in     = dv_q;
            word_in  = dv_word;
            state_in = S_MOD;
         end
         S_ELIG: begin
            elig_in  = el_vec;
            state_in = S_PICK;
         end
         S_PICK: begin
            sel_in  = pk_sel;
            word_in = pk_word;
            base_in = BASE_W'(first_ff[pk_sel]) + BASE_W'(int'(pk_k) * WORD_BITS);
            lim_in  = (pk_rem >= (SZ_W + 1)'(WORD_BITS)) ? LIM_W'(WORD_BITS) :
                      LIM_W'(pk_rem);
            if (pk_found) begin
               state_in = S_MOD;
            end else begin
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = bfa_pkg::ST_NONE;
               rsp_addr_in   = '0;
            end
         end
         S_MOD: begin
            if (op_ff == bfa_pkg::ACT_ALLOCATE) begin
               if (al_avail == '0) begin
                  // partial last word had nothing free: drop it and search again
                  skip_in[sel_ff] = 1'b1;
                  state_in        = S_ELIG;
               end else begin
                  wr_en           = 1'b1;
                  wr_data[al_bit] = 1'b1;
                  state_in        = S_IDLE;
                  rsp_valid_in    = 1'b1;
                  rsp_status_in   = bfa_pkg::ST_OK;
                  rsp_addr_in     = bfa_pkg::ADDR_W'({al_frame, {PAGE_SHIFT{1'b0}}});
               end
            end else begin
               wr_en        = 1'b1;
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               rsp_addr_in  = '0;
               if (op_ff == bfa_pkg::ACT_RESERVE) begin
                  if (rd_data[md_bit]) begin
                     rsp_status_in = bfa_pkg::ST_TAKEN;
                  end else begin
                     wr_data[md_bit] = 1'b1;
                     rsp_status_in   = bfa_pkg::ST_OK;
                  end
               end else begin
                  if (!rd_data[md_bit]) begin
                     rsp_status_in = bfa_pkg::ST_FREE;
                  end else begin
                     wr_data[md_bit] = 1'b0;
                     rsp_status_in   = bfa_pkg::ST_OK;
                  end
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // ---------------- sequencer registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         skip_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         skip_ff      <= skip_in;
      end
      op_ff         <= op_in;
      fn_ff         <= fn_in;
      sel_ff        <= sel_in;
      idx_ff        <= idx_in;
      q_ff          <= q_in;
      word_ff       <= word_in;
      base_ff       <= base_in;
      lim_ff        <= lim_in;
      elig_ff       <= elig_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
   end

   assign busy              = (state_ff != S_IDLE) || !mem_ready;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_frame_address = rsp_addr_ff;

endmodule

@@ hdl/bfa_checker.sv @@
// Port-level checks on the frame allocator, bound to the top level.
module bfa_port_checks (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic [bfa_pkg::ACTION_W-1:0]  req_action,
   input logic                          rsp_valid,
   input logic [bfa_pkg::STATUS_W-1:0]  rsp_status,
   input logic [bfa_pkg::ADDR_W-1:0]    rsp_frame_address
);

   // status stays within the defined codes
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= bfa_pkg::ST_NONE))
      else $error("status code out of range");

   // only a successful item carries an address
   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != bfa_pkg::ST_OK)) |-> (rsp_frame_address == '0))
      else $error("failed item returned a nonzero address");

   // bitmap actions occupy the block and answer later
   a_multi_cycle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_action == bfa_pkg::ACT_RESERVE ||
                          req_action == bfa_pkg::ACT_ALLOCATE ||
                          req_action == bfa_pkg::ACT_FREE)) |=> (busy && !rsp_valid))
      else $error("bitmap action did not hold the block busy");

   // an unknown action is answered at once with no such frame
   a_unknown: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !(req_action == bfa_pkg::ACT_RESERVE ||
                           req_action == bfa_pkg::ACT_ALLOCATE ||
                           req_action == bfa_pkg::ACT_FREE))
      |=> (rsp_valid && (rsp_status == bfa_pkg::ST_NO_FRAME)))
      else $error("unknown action not answered next cycle");

   // no result without work in flight
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) || $past(start)))
      else $error("result without a preceding item");

endmodule

bind bitmap_frame_allocator_core bfa_port_checks u_bfa_port_checks (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .req_action        (req_action),
   .rsp_valid         (rsp_valid),
   .rsp_status        (rsp_status),
   .rsp_frame_address (rsp_frame_address)
);

@@ sim/bfa_checker.sv @@
// Checker for the frame allocator: keeps its own bitmap, predicts each result and compares.
`timescale 1ns / 1ps
module bfa_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic [bfa_pkg::ACTION_W-1:0]  req_action,
   input  logic [bfa_pkg::ADDR_W-1:0]    req_phys_address,
   input  logic                          rsp_valid,
   input  logic [bfa_pkg::STATUS_W-1:0]  rsp_status,
   input  logic [bfa_pkg::ADDR_W-1:0]    rsp_frame_address,
   input  logic                          csr_we,
   input  logic [bfa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bfa_pkg::FRAME_W-1:0]   csr_wdata,
   output int                            fail_count,
   output int                            pending
);

   localparam int FRAMES_PER_SLOT = 4096;
   localparam int MAP_BITS        = 64;
   localparam int WORDS_PER_SLOT  = FRAMES_PER_SLOT / MAP_BITS;
   localparam int PAGE_BITS       = 12;

   typedef struct packed {
      bfa_pkg::status_type         status;
      logic [bfa_pkg::ADDR_W-1:0]  frame_address;
   } outcome_type;

   // Shadow of the block: occupancy words, region registers, results still owed
   logic [MAP_BITS-1:0]         frame_map [bfa_pkg::NUM_SLOTS*WORDS_PER_SLOT];
   logic [bfa_pkg::COUNT_W-1:0] slot_count;
   bfa_pkg::frame_num_type      slot_first [bfa_pkg::NUM_SLOTS];
   bfa_pkg::frame_num_type      slot_last  [bfa_pkg::NUM_SLOTS];
   outcome_type                 owed_outcomes [$];

   task automatic log_mismatch(string what);
      $display("[%0t] MISMATCH: %s", $realtime, what);
      fail_count++;
   endtask

   function automatic int live_slots();
      return (slot_count > bfa_pkg::NUM_SLOTS) ? bfa_pkg::NUM_SLOTS : int'(slot_count);
   endfunction

   // Frames owned by a slot; an oversized region keeps only its first FRAMES_PER_SLOT
   function automatic longint unsigned slot_span(int r);
      longint unsigned n;
      if (slot_last[r] < slot_first[r]) return 64'd0;
      n = {28'd0, slot_last[r]} - {28'd0, slot_first[r]} + 64'd1;
      return (n > 64'(FRAMES_PER_SLOT)) ? 64'(FRAMES_PER_SLOT) : n;
   endfunction

   // Lowest-index slot holding the frame wins on overlap
   function automatic bit find_slot(bfa_pkg::frame_num_type fn, output int word,
                                    output int pos);
      longint unsigned off;
      int r;
      word = 0;
      pos  = 0;
      for (r = 0; r < live_slots(); r++) begin
         if (fn >= slot_first[r]) begin
            off = {28'd0, fn} - {28'd0, slot_first[r]};
            if (off < slot_span(r)) begin
               word = r * WORDS_PER_SLOT + int'(off / MAP_BITS);
               pos  = int'(off % MAP_BITS);
               return 1'b1;
            end
         end
      end
      return 1'b0;
   endfunction

   // Apply one request to the shadow bitmap and return the result it must give
   function automatic outcome_type predict_outcome(bfa_pkg::action_type act,
                                                   logic [bfa_pkg::ADDR_W-1:0] addr);
      outcome_type            res;
      bfa_pkg::frame_num_type fn;
      int                     word, pos, r, k;
      longint unsigned        span, base;
      logic [MAP_BITS-1:0]    avail;
      logic [63:0]            frame;
      bit                     taken, done;
      res.status        = bfa_pkg::ST_NO_FRAME;
      res.frame_address = '0;
      fn = addr[bfa_pkg::ADDR_W-1:PAGE_BITS];
      if (act == bfa_pkg::ACT_RESERVE || act == bfa_pkg::ACT_FREE) begin
         if (find_slot(fn, word, pos)) begin
            taken = frame_map[word][pos];
            if (act == bfa_pkg::ACT_RESERVE) begin
               if (taken) begin
                  res.status = bfa_pkg::ST_TAKEN;
               end else begin
                  frame_map[word][pos] = 1'b1;
                  res.status = bfa_pkg::ST_OK;
               end
            end else if (!taken) begin
               res.status = bfa_pkg::ST_FREE;
            end else begin
               frame_map[word][pos] = 1'b0;
               res.status = bfa_pkg::ST_OK;
            end
         end
      end else if (act == bfa_pkg::ACT_ALLOCATE) begin
         res.status = bfa_pkg::ST_NONE;
         done = 1'b0;
         for (r = 0; r < live_slots() && !done; r++) begin
            span = slot_span(r);
            for (k = 0; k < WORDS_PER_SLOT && !done; k++) begin
               base = 64'(k * MAP_BITS);
               if (base >= span) break;
               avail = ~frame_map[r*WORDS_PER_SLOT + k];
               // partial last word: bits past the region end are not frames
               if (span - base < 64'(MAP_BITS)) avail &= (64'd1 << (span - base)) - 64'd1;
               if (avail != '0) begin
                  pos = 0;
                  while (!avail[pos]) pos++;
                  frame_map[r*WORDS_PER_SLOT + k][pos] = 1'b1;
                  frame = {28'd0, slot_first[r]} + base + 64'(pos);
                  res.frame_address = {frame[bfa_pkg::ADDR_W-PAGE_BITS-1:0],
                                       {PAGE_BITS{1'b0}}};
                  res.status = bfa_pkg::ST_OK;
                  done = 1'b1;
               end
            end
         end
      end
      return res;
   endfunction

   task automatic apply_register(logic [bfa_pkg::CSR_IDX_W-1:0] idx,
                                 bfa_pkg::frame_num_type data);
      case (idx)
         bfa_pkg::CSR_REGION_COUNT: slot_count    = data[bfa_pkg::COUNT_W-1:0];
         bfa_pkg::CSR_R0_FIRST:     slot_first[0] = data;
         bfa_pkg::CSR_R0_LAST:      slot_last[0]  = data;
         bfa_pkg::CSR_R1_FIRST:     slot_first[1] = data;
         bfa_pkg::CSR_R1_LAST:      slot_last[1]  = data;
         bfa_pkg::CSR_R2_FIRST:     slot_first[2] = data;
         bfa_pkg::CSR_R2_LAST:      slot_last[2]  = data;
         default: ;
      endcase
   endtask

   // Results are checked before this edge's item is predicted
   always @(posedge clock) begin : watch
      outcome_type want;
      int          i;
      if (reset) begin
         slot_count = bfa_pkg::COUNT_W'(1);
         for (i = 0; i < bfa_pkg::NUM_SLOTS; i++) begin
            slot_first[i] = '0;
            slot_last[i]  = '0;
         end
         slot_last[0] = bfa_pkg::FRAME_W'(4095);
         for (i = 0; i < bfa_pkg::NUM_SLOTS*WORDS_PER_SLOT; i++) frame_map[i] = '0;
         owed_outcomes.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid === 1'b1) begin
            if (owed_outcomes.size() == 0) begin
               log_mismatch($sformatf("result with none owed: status %0d address %h",
                                      rsp_status, rsp_frame_address));
            end else begin
               want = owed_outcomes.pop_front();
               if (rsp_status !== want.status)
                  log_mismatch($sformatf("status %0d, expected %0d", rsp_status, want.status));
               if (rsp_frame_address !== want.frame_address)
                  log_mismatch($sformatf("frame_address %h, expected %h",
                                         rsp_frame_address, want.frame_address));
            end
         end
         if (csr_we) apply_register(csr_index, csr_wdata);
         if (start && !busy)
            owed_outcomes.push_back(predict_outcome(req_action, req_phys_address));
      end
      pending = owed_outcomes.size();
   end

endmodule

@@ sim/tb_top.sv @@
// Testbench top for the frame allocator: clock, reset, request and register stimulus, verdict.
`timescale 1ns / 1ps
module tb_top;

   localparam int                     PAGE_BITS       = 12;
   localparam int                     WATCHDOG_LIMIT  = 2000;
   localparam int                     ITEMS_PER_PHASE = 107;
   localparam int                     RANDOM_PHASES   = 10;
   localparam bfa_pkg::frame_num_type FRAME_MAX       = {bfa_pkg::FRAME_W{1'b1}};
   localparam bfa_pkg::action_type    ACT_UNUSED      = 2'd3;

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic [bfa_pkg::ACTION_W-1:0]  req_action;
   logic [bfa_pkg::ADDR_W-1:0]    req_phys_address;
   logic                          rsp_valid;
   logic [bfa_pkg::STATUS_W-1:0]  rsp_status;
   logic [bfa_pkg::ADDR_W-1:0]    rsp_frame_address;
   logic                          csr_we;
   logic [bfa_pkg::CSR_IDX_W-1:0] csr_index;
   logic [bfa_pkg::FRAME_W-1:0]   csr_wdata;
   int                            fail_count;
   int                            pending;

   // Region layout currently loaded, used to aim addresses at live frames
   bfa_pkg::frame_num_type cfg_first [bfa_pkg::NUM_SLOTS];
   bfa_pkg::frame_num_type cfg_last  [bfa_pkg::NUM_SLOTS];
   int                     sent_by_action [4];
   int                     settings;
   int                     quiet_cycles;
   bit                     idle_on;

   bitmap_frame_allocator_core dut (.*);
   bfa_checker chk (.*);

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watchdog: too long without an item taken or a result shown
   initial quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic send_item(bfa_pkg::action_type act, logic [bfa_pkg::ADDR_W-1:0] addr);
      int gap;
      gap = idle_on ? int'($urandom_range(0, 16)) : 0;
      @(negedge clock);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      start            = 1'b1;
      req_action       = act;
      req_phys_address = addr;
      do @(posedge clock); while (busy);
      sent_by_action[act]++;
   endtask

   // Hold off until every owed result has come back
   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic write_reg(logic [bfa_pkg::CSR_IDX_W-1:0] idx, bfa_pkg::frame_num_type data);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
   endtask

   // Load cfg_first/cfg_last and a region count; upper count bits get noise
   task automatic commit_regions(logic [bfa_pkg::COUNT_W-1:0] count);
      logic [63:0] noise;
      noise = {$urandom, $urandom};
      drain();
      write_reg(bfa_pkg::CSR_REGION_COUNT,
                {noise[bfa_pkg::FRAME_W-1:bfa_pkg::COUNT_W], count});
      write_reg(bfa_pkg::CSR_R0_FIRST, cfg_first[0]);
      write_reg(bfa_pkg::CSR_R0_LAST,  cfg_last[0]);
      write_reg(bfa_pkg::CSR_R1_FIRST, cfg_first[1]);
      write_reg(bfa_pkg::CSR_R1_LAST,  cfg_last[1]);
      write_reg(bfa_pkg::CSR_R2_FIRST, cfg_first[2]);
      write_reg(bfa_pkg::CSR_R2_LAST,  cfg_last[2]);
      @(negedge clock);
      csr_we = 1'b0;
      settings++;
   endtask

   task automatic random_regions();
      logic [63:0] w;
      int          r, kind;
      for (r = 0; r < bfa_pkg::NUM_SLOTS; r++) begin
         w    = {$urandom, $urandom};
         kind = int'($urandom_range(0, 5));
         if (kind == 5 && r == 0) kind = 1;
         case (kind)
            0: begin   // small, anywhere in frame space
               cfg_first[r] = w[bfa_pkg::FRAME_W-1:0];
               cfg_last[r]  = cfg_first[r] + bfa_pkg::FRAME_W'($urandom_range(0, 130));
            end
            1: begin   // small, low frames
               cfg_first[r] = bfa_pkg::FRAME_W'($urandom_range(0, 5000));
               cfg_last[r]  = cfg_first[r] + bfa_pkg::FRAME_W'($urandom_range(0, 90));
            end
            2: begin   // exactly full size
               cfg_first[r] = w[bfa_pkg::FRAME_W-1:0];
               cfg_last[r]  = cfg_first[r] + bfa_pkg::FRAME_W'(4095);
            end
            3: begin   // oversized
               cfg_first[r] = w[bfa_pkg::FRAME_W-1:0] >> $urandom_range(0, 35);
               cfg_last[r]  = $urandom_range(0, 1) ? FRAME_MAX
                              : cfg_first[r] + bfa_pkg::FRAME_W'(4096)
                                + bfa_pkg::FRAME_W'($urandom_range(0, 9000));
            end
            4: begin   // empty: last below first
               cfg_first[r] = w[bfa_pkg::FRAME_W-1:0] | bfa_pkg::FRAME_W'(1);
               cfg_last[r]  = cfg_first[r] >> 1;
            end
            default: begin   // overlaps the slot below
               cfg_first[r] = cfg_first[r-1] + bfa_pkg::FRAME_W'($urandom_range(0, 40));
               cfg_last[r]  = cfg_first[r] + bfa_pkg::FRAME_W'($urandom_range(0, 80));
            end
         endcase
      end
      commit_regions(($urandom_range(0, 9) == 0) ? bfa_pkg::COUNT_W'(0)
                     : bfa_pkg::COUNT_W'($urandom_range(1, 3)));
   endtask

   function automatic bfa_pkg::action_type pick_action();
      int roll;
      roll = int'($urandom_range(0, 99));
      if (roll < 40) return bfa_pkg::ACT_ALLOCATE;
      if (roll < 68) return bfa_pkg::ACT_RESERVE;
      if (roll < 96) return bfa_pkg::ACT_FREE;
      return ACT_UNUSED;
   endfunction

   // Mostly frames in or just past a region, biased to its low end; some raw noise
   function automatic logic [bfa_pkg::ADDR_W-1:0] pick_address();
      logic [63:0]            noise;
      longint unsigned        reach;
      int                     r, off;
      bfa_pkg::frame_num_type fn;
      noise = {$urandom, $urandom};
      if ($urandom_range(0, 99) < 12) return noise[bfa_pkg::ADDR_W-1:0];
      r = int'($urandom_range(0, bfa_pkg::NUM_SLOTS-1));
      if (cfg_last[r] >= cfg_first[r])
         reach = {28'd0, cfg_last[r]} - {28'd0, cfg_first[r]} + 64'd2;
      else
         reach = 64'd2;
      if (reach > 64'd160 && $urandom_range(0, 1)) reach = 64'd160;
      if (reach > 64'd4100) reach = 64'd4100;
      off = int'($urandom_range(0, int'(reach)));
      fn  = cfg_first[r] + bfa_pkg::FRAME_W'(off);
      return {fn, noise[PAGE_BITS-1:0]};
   endfunction

   task automatic run_phase(int n);
      int i;
      for (i = 0; i < n; i++) begin
         // idle on or off in stretches
         if (i % 36 == 0) idle_on = ($urandom_range(0, 3) != 0);
         if (i == n / 2) drain();
         send_item(pick_action(), pick_address());
      end
   endtask

   initial begin : stimulus
      int p;
      reset            = 1'b1;
      start            = 1'b0;
      req_action       = bfa_pkg::ACT_RESERVE;
      req_phys_address = '0;
      csr_we           = 1'b0;
      csr_index        = bfa_pkg::CSR_REGION_COUNT;
      csr_wdata        = '0;
      idle_on          = 1'b1;
      settings         = 0;
      sent_by_action   = '{default: 0};
      cfg_first        = '{default: '0};
      cfg_last         = '{36'd4095, 36'd0, 36'd0};
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset layout: one region of frames 0..4095
      send_item(bfa_pkg::ACT_RESERVE,  48'h0);
      send_item(bfa_pkg::ACT_RESERVE,  48'h0_0000_0FFF);
      send_item(bfa_pkg::ACT_FREE,     48'h0_0000_0123);
      send_item(bfa_pkg::ACT_FREE,     48'h0);
      send_item(bfa_pkg::ACT_RESERVE,  48'h0_0000_FFFF_FF);
      send_item(bfa_pkg::ACT_RESERVE,  48'h0_0001_0000_00);
      send_item(bfa_pkg::ACT_RESERVE,  48'hFFFF_FFFF_FFFF);
      send_item(bfa_pkg::ACT_FREE,     48'hFFFF_FFFF_FFFF);
      send_item(bfa_pkg::ACT_ALLOCATE, 48'hFFFF_FFFF_FFFF);
      send_item(bfa_pkg::ACT_ALLOCATE, 48'h0);
      send_item(ACT_UNUSED,            48'hFFFF_FFFF_FFFF);
      send_item(bfa_pkg::ACT_FREE,     48'h0_0000_1000);
      send_item(bfa_pkg::ACT_ALLOCATE, 48'h0);

      // No region active
      commit_regions(2'd0);
      send_item(bfa_pkg::ACT_RESERVE,  48'h0);
      send_item(bfa_pkg::ACT_FREE,     48'h0_0000_0FFF);
      send_item(bfa_pkg::ACT_ALLOCATE, 48'h0);
      send_item(ACT_UNUSED,            48'h0);

      // Top of frame space, an oversized region and an empty one
      cfg_first = '{FRAME_MAX - 36'd99, 36'd0,     36'd50};
      cfg_last  = '{FRAME_MAX,          FRAME_MAX, 36'd10};
      commit_regions(2'd3);
      send_item(bfa_pkg::ACT_RESERVE,  48'hFFFF_FFFF_FFFF);
      send_item(bfa_pkg::ACT_RESERVE,  48'h0_0001_0000_00);
      send_item(bfa_pkg::ACT_ALLOCATE, 48'h0);
      run_phase(ITEMS_PER_PHASE);

      // Overlapping regions
      cfg_first = '{36'd1000, 36'd1030, 36'd1000};
      cfg_last  = '{36'd1069, 36'd1100, 36'd1000};
      commit_regions(2'd3);
      run_phase(ITEMS_PER_PHASE);

      // Tiny regions that run out; the unused third slot must be ignored
      cfg_first = '{36'd7, 36'd300, 36'd0};
      cfg_last  = '{36'd7, 36'd319, 36'd4095};
      commit_regions(2'd2);
      run_phase(ITEMS_PER_PHASE);

      for (p = 0; p < RANDOM_PHASES; p++) begin
         random_regions();
         run_phase(ITEMS_PER_PHASE);
      end

      drain();
      repeat (20) @(negedge clock);
      $display("Covered %0d reserve, %0d allocate, %0d free and %0d undefined requests",
               sent_by_action[bfa_pkg::ACT_RESERVE], sent_by_action[bfa_pkg::ACT_ALLOCATE],
               sent_by_action[bfa_pkg::ACT_FREE], sent_by_action[ACT_UNUSED]);
      $display("over %0d region layouts: empty, overlapping, oversized, exhausted, top of space",
               settings);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

@@ files.f @@
hdl/bfa_pkg.sv
hdl/bfa_bitmap.sv
hdl/bitmap_frame_allocator_core.sv
hdl/bfa_checker.sv
sim/bfa_checker.sv
sim/tb_top.sv
